// ===== rtl/core/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, sizes and reset helpers for the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int NUM_BLOCKS     = 512;
    localparam int RESERVED_START = 0;
    localparam int RESERVED_COUNT = 1;
    localparam int WORD_BITS      = 64;

    localparam int MAP_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIDX_W     = $clog2(WORD_BITS);
    localparam int ID_W       = 10;
    localparam int CNT_W      = 10;
    localparam int OP_W       = 2;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 32;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_REQUEST = 2'd1,
        OP_RELEASE = 2'd2
    } t_op;

    // bits of map word w that name real blocks
    function automatic t_word word_mask(input int w);
        t_word m;
        m = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (w * WORD_BITS + b < NUM_BLOCKS) begin
                m[b] = 1'b1;
            end
        end
        return m;
    endfunction

    // reserved blocks that hold the map itself
    function automatic t_word reset_word(input int w);
        t_word m;
        int    id;
        m = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            id = w * WORD_BITS + b;
            if (id >= RESERVED_START && id < RESERVED_START + RESERVED_COUNT
                    && id < NUM_BLOCKS) begin
                m[b] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic logic [CNT_W-1:0] reset_used();
        int n;
        n = 0;
        for (int i = 0; i < RESERVED_COUNT; i++) begin
            if (RESERVED_START + i < NUM_BLOCKS) begin
                n = n + 1;
            end
        end
        return CNT_W'(n);
    endfunction

endpackage

// ===== rtl/core/bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// Used/free bitmap over a fixed block store with allocate, request, release.
// ----------------------------------------------------------------------------
// One word in gives one word out. An allocate walks the map one 64-bit word
// per cycle through a single find-first-zero unit, from word 0 up to the
// first word with a free bit or the last word, and then posts the result;
// request and release touch only the one map word that holds the block. The
// input side is ready only while no operation is in progress; a finished
// result sits in the output register and does not hold off the next word.
// After reset only the reserved blocks that hold the map are marked used.
module bitmap_block_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [bba_pkg::S_DATA_W-1:0]  i_s_tdata,  // op[1:0], blk_num[11:2]
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [bba_pkg::M_DATA_W-1:0]  o_m_tdata   // success[0], granted_id[10:1],
                                                      // used_count[20:11],
                                                      // free_count[30:21]
);

    bba_pkg::t_state                   r_state, n_state;
    bba_pkg::t_word                    r_map [bba_pkg::MAP_WORDS];
    logic [bba_pkg::CNT_W-1:0]         r_used, n_used;
    logic [bba_pkg::WIDX_W-1:0]        r_idx, n_idx;
    bba_pkg::t_op                      r_op, n_op;
    logic [bba_pkg::ID_W-1:0]          r_id, n_id;
    logic                              r_ok, n_ok;
    logic [bba_pkg::ID_W-1:0]          r_gid, n_gid;
    logic                              r_out_vld, n_out_vld;
    logic [bba_pkg::M_DATA_W-1:0]      r_out, n_out;

    logic                              s_accept;
    logic                              m_free;
    bba_pkg::t_word                    cur_word;
    bba_pkg::t_word                    free_bits;
    logic                              ffz_found;
    logic [bba_pkg::BIDX_W-1:0]        ffz_pos;
    logic                              id_in_range;
    logic [bba_pkg::BIDX_W-1:0]        id_bit;
    logic                              wr_en;
    bba_pkg::t_word                    wr_word;
    logic [bba_pkg::CNT_W-1:0]         free_cnt;

    assign s_accept = i_s_tvalid && o_s_tready;
    assign m_free   = !r_out_vld || i_m_tready;

    // find-first-zero unit, shared by every word of the scan
    assign cur_word  = r_map[r_idx];
    assign free_bits = ~cur_word & bba_pkg::word_mask(int'(r_idx));
    assign ffz_found = |free_bits;

    always_comb begin
        ffz_pos = '0;
        for (int b = bba_pkg::WORD_BITS - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                ffz_pos = bba_pkg::BIDX_W'(b);
            end
        end
    end

    assign id_in_range = int'(r_id) < bba_pkg::NUM_BLOCKS;
    assign id_bit      = r_id[bba_pkg::BIDX_W-1:0];
    assign free_cnt    = bba_pkg::CNT_W'(bba_pkg::NUM_BLOCKS - int'(r_used));

    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_idx     = r_idx;
        n_op      = r_op;
        n_id      = r_id;
        n_ok      = r_ok;
        n_gid     = r_gid;
        n_out_vld = r_out_vld;
        n_out     = r_out;
        wr_en     = 1'b0;
        wr_word   = cur_word;
        o_s_tready = (r_state == bba_pkg::S_IDLE);

        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            bba_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_op  = bba_pkg::t_op'(i_s_tdata[bba_pkg::OP_W-1:0]);
                    n_id  = i_s_tdata[bba_pkg::OP_W +: bba_pkg::ID_W];
                    n_ok  = 1'b0;
                    n_gid = '0;
                    if (bba_pkg::t_op'(i_s_tdata[bba_pkg::OP_W-1:0])
                            == bba_pkg::OP_ALLOC) begin
                        n_idx = '0;
                    end else begin
                        n_idx = i_s_tdata[bba_pkg::OP_W + bba_pkg::BIDX_W +: bba_pkg::WIDX_W];
                    end
                    n_state = bba_pkg::S_SCAN;
                end
            end
            bba_pkg::S_SCAN: begin
                case (r_op)
                    bba_pkg::OP_ALLOC: begin
                        if (ffz_found) begin
                            wr_en           = 1'b1;
                            wr_word[ffz_pos] = 1'b1;
                            n_used          = r_used + 1'b1;
                            n_ok            = 1'b1;
                            n_gid           = bba_pkg::ID_W'({r_idx, ffz_pos});
                            n_state         = bba_pkg::S_DONE;
                        end else if (int'(r_idx) == bba_pkg::MAP_WORDS - 1) begin
                            n_state = bba_pkg::S_DONE;  // store full
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                    bba_pkg::OP_REQUEST: begin
                        if (id_in_range && !cur_word[id_bit]) begin
                            wr_en           = 1'b1;
                            wr_word[id_bit] = 1'b1;
                            n_used          = r_used + 1'b1;
                            n_ok            = 1'b1;
                        end
                        n_state = bba_pkg::S_DONE;
                    end
                    bba_pkg::OP_RELEASE: begin
                        if (id_in_range) begin
                            n_ok = 1'b1;
                            if (cur_word[id_bit]) begin
                                wr_en           = 1'b1;
                                wr_word[id_bit] = 1'b0;
                                n_used          = r_used - 1'b1;
                            end
                        end
                        n_state = bba_pkg::S_DONE;
                    end
                    default: begin
                        n_state = bba_pkg::S_DONE;
                    end
                endcase
            end
            bba_pkg::S_DONE: begin
                if (m_free) begin
                    n_out_vld = 1'b1;
                    n_out     = {1'b0, free_cnt, r_used, r_gid, r_ok};
                    n_state   = bba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bba_pkg::S_IDLE;
            r_used    <= bba_pkg::reset_used();
            r_out_vld <= 1'b0;
            for (int w = 0; w < bba_pkg::MAP_WORDS; w++) begin
                r_map[w] <= bba_pkg::reset_word(w);
            end
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_out_vld <= n_out_vld;
            if (wr_en) begin
                r_map[r_idx] <= wr_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_op  <= n_op;
        r_id  <= n_id;
        r_ok  <= n_ok;
        r_gid <= n_gid;
        r_out <= n_out;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out;

    // ------------------------------------------------------------------------
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_state == bba_pkg::S_SCAN)
        else $error("accepted word did not start a scan");

    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_used == $past(r_used)
            || r_used == $past(r_used) + 1'b1
            || r_used == $past(r_used) - 1'b1))
        else $error("used count moved by more than one");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_used) <= bba_pkg::NUM_BLOCKS)
        else $error("used count above block count");

    a_map_write_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> r_state == bba_pkg::S_SCAN && n_state == bba_pkg::S_DONE)
        else $error("map written outside the final scan step");

endmodule

// ===== tb/sv/bitmap_block_allocator_test.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator_test
// Self-checking bench: drives allocate/request/release/undefined words, predicts
// every result word from a local copy of the used map, and compares field by field.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_test;

    localparam logic [bba_pkg::OP_W-1:0] OP_UNDEFINED = 2'd3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_SHOWN    = 10;
    localparam int MIX_ITEMS    = 170;

    typedef struct packed {
        logic [bba_pkg::CNT_W-1:0] free_count;
        logic [bba_pkg::CNT_W-1:0] used_count;
        logic [bba_pkg::ID_W-1:0]  granted_id;
        logic                      success;
    } t_alloc_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [bba_pkg::S_DATA_W-1:0]  i_s_tdata = '0;   // op[1:0], blk_num[11:2]
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [bba_pkg::M_DATA_W-1:0]  o_m_tdata;        // success[0], granted_id[10:1],
                                                     // used_count[20:11],
                                                     // free_count[30:21]

    // local view of the block map
    logic [bba_pkg::NUM_BLOCKS-1:0] block_used;
    int                             blocks_in_use;

    t_alloc_result expected_results[$];
    int            mismatches = 0;
    int            cycle_count = 0;
    int            idle_pct = 0;
    int            stall_pct = 0;

    bitmap_block_allocator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Applies one operation to the local map and returns the result word.
    function automatic t_alloc_result predict_result(
            input logic [bba_pkg::OP_W-1:0] op,
            input logic [bba_pkg::ID_W-1:0] id);
        t_alloc_result r;
        logic          found;
        r = '0;
        found = 1'b0;
        case (op)
            bba_pkg::OP_ALLOC: begin
                for (int n = 0; n < bba_pkg::NUM_BLOCKS; n++) begin
                    if (!found && !block_used[n]) begin
                        found = 1'b1;
                        block_used[n] = 1'b1;
                        blocks_in_use++;
                        r.success = 1'b1;
                        r.granted_id = bba_pkg::ID_W'(n);
                    end
                end
            end
            bba_pkg::OP_REQUEST: begin
                if (id < bba_pkg::NUM_BLOCKS && !block_used[id]) begin
                    block_used[id] = 1'b1;
                    blocks_in_use++;
                    r.success = 1'b1;
                end
            end
            bba_pkg::OP_RELEASE: begin
                if (id < bba_pkg::NUM_BLOCKS) begin
                    if (block_used[id]) begin
                        block_used[id] = 1'b0;
                        blocks_in_use--;
                    end
                    r.success = 1'b1;
                end
            end
            default: ;
        endcase
        r.used_count = bba_pkg::CNT_W'(blocks_in_use);
        r.free_count = bba_pkg::CNT_W'(bba_pkg::NUM_BLOCKS - blocks_in_use);
        return r;
    endfunction

    task automatic send_word(input logic [bba_pkg::OP_W-1:0] op,
                             input logic [bba_pkg::ID_W-1:0] id);
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0000, id, op};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        expected_results.push_back(predict_result(op, id));
    endtask

    task automatic test_directed();
        send_word(bba_pkg::OP_ALLOC, 10'd0);       // lowest free sits above the reserved one
        send_word(bba_pkg::OP_ALLOC, 10'h3FF);     // id ignored by allocate
        send_word(bba_pkg::OP_REQUEST, 10'd0);     // reserved block, already used
        send_word(bba_pkg::OP_REQUEST, 10'h3FF);   // out of range
        send_word(bba_pkg::OP_REQUEST, 10'd512);
        send_word(bba_pkg::OP_RELEASE, 10'd512);
        send_word(bba_pkg::OP_RELEASE, 10'h3FF);
        send_word(bba_pkg::OP_REQUEST, 10'd511);   // top block
        send_word(bba_pkg::OP_REQUEST, 10'd511);   // now used
        send_word(bba_pkg::OP_RELEASE, 10'd511);
        send_word(bba_pkg::OP_RELEASE, 10'd511);   // already free, still succeeds
        send_word(bba_pkg::OP_RELEASE, 10'd0);     // give back the reserved block
        send_word(bba_pkg::OP_ALLOC, 10'd0);
        send_word(OP_UNDEFINED, 10'h3FF);
        send_word(OP_UNDEFINED, 10'd0);
        send_word(bba_pkg::OP_REQUEST, 10'd63);    // map word boundary
        send_word(bba_pkg::OP_REQUEST, 10'd64);
        send_word(bba_pkg::OP_RELEASE, 10'd1);
        send_word(bba_pkg::OP_ALLOC, 10'h155);
        send_word(bba_pkg::OP_ALLOC, 10'h2AA);
        send_word(bba_pkg::OP_RELEASE, 10'd2);
        send_word(bba_pkg::OP_RELEASE, 10'd63);
        send_word(bba_pkg::OP_ALLOC, 10'd0);
        send_word(bba_pkg::OP_ALLOC, 10'd0);
    endtask

    // Fill the whole store, hit the full case, punch holes and refill them.
    task automatic test_fill_and_refill();
        while (blocks_in_use < bba_pkg::NUM_BLOCKS) begin
            send_word(bba_pkg::OP_ALLOC, bba_pkg::ID_W'($urandom_range(1023)));
        end
        repeat (3) send_word(bba_pkg::OP_ALLOC, bba_pkg::ID_W'($urandom_range(1023)));
        send_word(bba_pkg::OP_REQUEST,
                  bba_pkg::ID_W'($urandom_range(bba_pkg::NUM_BLOCKS - 1)));
        repeat (48) begin
            send_word(bba_pkg::OP_RELEASE,
                      bba_pkg::ID_W'($urandom_range(bba_pkg::NUM_BLOCKS - 1)));
        end
        repeat (8) begin
            send_word(bba_pkg::OP_REQUEST,
                      bba_pkg::ID_W'($urandom_range(bba_pkg::NUM_BLOCKS - 1)));
        end
        while (blocks_in_use < bba_pkg::NUM_BLOCKS) begin
            send_word(bba_pkg::OP_ALLOC, bba_pkg::ID_W'($urandom_range(1023)));
        end
        send_word(bba_pkg::OP_ALLOC, bba_pkg::ID_W'($urandom_range(1023)));
    endtask

    task automatic test_random_mix(input int count, input int alloc_pct);
        int                       start;
        int                       pick;
        logic [bba_pkg::OP_W-1:0] op;
        logic [bba_pkg::ID_W-1:0] id;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if ($urandom_range(99) < alloc_pct) begin
                op = bba_pkg::OP_ALLOC;
                id = bba_pkg::ID_W'($urandom_range(1023));
            end else if (pick < 55) begin
                op = bba_pkg::OP_RELEASE;
                start = $urandom_range(bba_pkg::NUM_BLOCKS - 1);
                id = bba_pkg::ID_W'(start);
                // mostly aim at a block that is in use
                if ($urandom_range(3) != 0) begin
                    for (int k = bba_pkg::NUM_BLOCKS - 1; k >= 0; k--) begin
                        if (block_used[(start + k) % bba_pkg::NUM_BLOCKS]) begin
                            id = bba_pkg::ID_W'((start + k) % bba_pkg::NUM_BLOCKS);
                        end
                    end
                end
            end else if (pick < 80) begin
                op = bba_pkg::OP_REQUEST;
                id = bba_pkg::ID_W'($urandom_range(bba_pkg::NUM_BLOCKS - 1));
            end else if (pick < 92) begin
                op = ($urandom_range(1) != 0) ? bba_pkg::OP_RELEASE : bba_pkg::OP_REQUEST;
                id = bba_pkg::ID_W'($urandom_range(1023, bba_pkg::NUM_BLOCKS));
            end else begin
                op = OP_UNDEFINED;
                id = bba_pkg::ID_W'($urandom_range(1023));
            end
            send_word(op, id);
        end
    endtask

    // result checker and receiver back-pressure
    always @(posedge i_clk) begin
        t_alloc_result got;
        t_alloc_result want;
        got = t_alloc_result'(o_m_tdata[30:0]);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("unexpected result word %h", o_m_tdata);
                end
            end else begin
                want = expected_results.pop_front();
                if (got.success !== want.success || got.granted_id !== want.granted_id
                        || got.used_count !== want.used_count
                        || got.free_count !== want.free_count) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN) begin
                        $display({"mismatch: success %0d/%0d granted %0d/%0d ",
                                  "used %0d/%0d free %0d/%0d (exp/act)"},
                                 want.success, got.success, want.granted_id, got.granted_id,
                                 want.used_count, got.used_count,
                                 want.free_count, got.free_count);
                    end
                end
            end
        end
        i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        block_used = '0;
        blocks_in_use = 0;
        for (int i = 0; i < bba_pkg::RESERVED_COUNT; i++) begin
            if (bba_pkg::RESERVED_START + i < bba_pkg::NUM_BLOCKS
                    && !block_used[bba_pkg::RESERVED_START + i]) begin
                block_used[bba_pkg::RESERVED_START + i] = 1'b1;
                blocks_in_use++;
            end
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 0;
        stall_pct = 0;
        test_directed();
        test_fill_and_refill();
        test_random_mix(MIX_ITEMS, 25);

        idle_pct = 60;
        test_random_mix(MIX_ITEMS, 70);

        idle_pct = 0;
        stall_pct = 60;
        test_random_mix(MIX_ITEMS, 30);

        idle_pct = 15;
        stall_pct = 15;
        test_random_mix(MIX_ITEMS, 65);

        i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/bba_pkg.sv
rtl/core/bitmap_block_allocator.sv
tb/sv/bitmap_block_allocator_test.sv
